### src/vehicle_pose_from_markers_assert.svh
`ifndef VEHICLE_POSE_FROM_MARKERS_ASSERT_SVH
`define VEHICLE_POSE_FROM_MARKERS_ASSERT_SVH

// Checked only out of reset.
`define VPFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked also while reset is applied.
`define VPFM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/vpfm_pkg.sv
package vpfm_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int NUM_REGS = 5;
	localparam int REG_W = 64;
	localparam int IDX_W = 3;
	localparam int POS_W = 24;
	localparam int YAW_W = 16;
	localparam int ID_W = 8;
	localparam int TIME_W = 64;
	localparam int COEF_W = 16;

	// direction vectoring, unit vector, products and sums
	localparam int DIR_W = 29;
	localparam int UNIT_W = 19;
	localparam int PROD_W = POS_W + COEF_W;
	localparam int SUM_W = 44;
	localparam int VEC_W = 47;
	localparam int ANG_W = 32;

	localparam logic signed [UNIT_W-1:0] UNIT_START = 19'sd39797;
	localparam logic signed [POS_W-1:0] FEAT_ONE = 24'sd65536;
	localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
	localparam logic signed [YAW_W-1:0] YAW_LIMIT = 16'sd25736;
	localparam logic signed [POS_W-1:0] POS_MAX = 24'sd8388607;
	localparam logic signed [POS_W-1:0] POS_MIN = -24'sd8388608;

	typedef enum logic [IDX_W-1:0] {
		REG_BACK_X = 3'd0,
		REG_BACK_Y = 3'd1,
		REG_DIR_X  = 3'd2,
		REG_DIR_Y  = 3'd3,
		REG_OFFSET = 3'd4
	} reg_idx_t;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		64'h000000000000100E, 64'h00000000100E0000, 64'hFFEA100000000144,
		64'h1000001001440000, 64'h0
	};

	// atan(2^-i), full circle = 2^32
	localparam logic [ANG_W-1:0] ATAN_BAM [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// side data through the first CORDIC and the calibration
	typedef struct packed {
		logic signed [POS_W-1:0] mid_x;
		logic signed [POS_W-1:0] mid_y;
		logic [ID_W-1:0]         id;
		logic [TIME_W-1:0]       tm;
		logic                    degen;
	} side_a_t;

	// side data through the yaw CORDIC
	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic [ID_W-1:0]         id;
		logic [TIME_W-1:0]       tm;
		logic                    degen;
		logic                    yaw_zero;
	} side_b_t;

endpackage

### src/vpfm_pts_if.sv
interface vpfm_pts_if;
	import vpfm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] back_left_x;
	logic signed [POS_W-1:0] back_left_y;
	logic signed [POS_W-1:0] back_right_x;
	logic signed [POS_W-1:0] back_right_y;
	logic signed [POS_W-1:0] front_x;
	logic signed [POS_W-1:0] front_y;
	logic [ID_W-1:0]         car_id;
	logic [TIME_W-1:0]       frame_time;

	modport source (output valid, back_left_x, back_left_y, back_right_x, back_right_y,
		front_x, front_y, car_id, frame_time, input ready);
	modport sink (input valid, back_left_x, back_left_y, back_right_x, back_right_y,
		front_x, front_y, car_id, frame_time, output ready);
endinterface

### src/vpfm_pose_if.sv
interface vpfm_pose_if;
	import vpfm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pose_x;
	logic signed [POS_W-1:0] pose_y;
	logic signed [YAW_W-1:0] yaw;
	logic [ID_W-1:0]         out_car_id;
	logic [TIME_W-1:0]       out_time;
	logic                    degenerate;

	modport source (output valid, pose_x, pose_y, yaw, out_car_id, out_time,
		degenerate, input ready);
	modport sink (input valid, pose_x, pose_y, yaw, out_car_id, out_time,
		degenerate, output ready);
endinterface

### src/vehicle_pose_from_markers.sv
// Pose pipeline: accepts one marker set per cycle unless held, and delivers one pose
// per request, in order. Stages: one input stage, CORDIC_STAGES (at most TABLE_LEN)
// of the direction CORDIC (vectoring and unit-vector rotation run side by side),
// unit vector, calibration products, calibration sums, pose rounding, as many of the
// yaw CORDIC, the angle multiply and the output register. The whole pipeline holds
// while a finished pose is not taken. The user must write calibration coefficients
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`include "vehicle_pose_from_markers_assert.svh"

module vehicle_pose_from_markers #(
	parameter int CORDIC_STAGES = vpfm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [vpfm_pkg::IDX_W-1:0] cfg_index,
	input  logic [vpfm_pkg::REG_W-1:0] cfg_data,
	vpfm_pts_if.sink                   pts,
	vpfm_pose_if.source                pose
);
	import vpfm_pkg::*;

	localparam int N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	logic en;
	logic [REG_W-1:0] regs_q [NUM_REGS];

	assign en = !pose.valid || pose.ready;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) regs_q[r] <= REG_RESET[r];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BACK_X: regs_q[0] <= cfg_data;
				REG_BACK_Y: regs_q[1] <= cfg_data;
				REG_DIR_X:  regs_q[2] <= cfg_data;
				REG_DIR_Y:  regs_q[3] <= cfg_data;
				REG_OFFSET: regs_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- stage 1: midpoint, doubled direction, half-plane flip
	logic signed [DIR_W-1:0] dx, dy;
	logic signed [POS_W:0]   sum_x, sum_y;
	logic                    v_s1;
	logic                    flip_s1;
	side_a_t                 side_s1;
	logic signed [DIR_W-1:0] dx_s1, dy_s1;

	always_comb begin
		sum_x = (POS_W+1)'(pts.back_left_x) + (POS_W+1)'(pts.back_right_x);
		sum_y = (POS_W+1)'(pts.back_left_y) + (POS_W+1)'(pts.back_right_y);
		dx = (DIR_W'(pts.front_x) <<< 1) - DIR_W'(sum_x);
		dy = (DIR_W'(pts.front_y) <<< 1) - DIR_W'(sum_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pts.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_s1 <= dx < 0;
			dx_s1 <= (dx < 0) ? -dx : dx;
			dy_s1 <= (dx < 0) ? -dy : dy;
			side_s1.mid_x <= POS_W'(sum_x >>> 1);
			side_s1.mid_y <= POS_W'(sum_y >>> 1);
			side_s1.id <= pts.car_id;
			side_s1.tm <= pts.frame_time;
			side_s1.degen <= (dx == 0) && (dy == 0);
		end
	end

	// ---- direction CORDIC: vectoring steers the unit-vector rotation
	logic                    v_c [N+1];
	logic                    flip_c [N+1];
	side_a_t                 side_c [N+1];
	logic signed [DIR_W-1:0] vx_c [N+1];
	logic signed [DIR_W-1:0] vy_c [N+1];
	logic signed [UNIT_W-1:0] rx_c [N+1];
	logic signed [UNIT_W-1:0] ry_c [N+1];

	assign v_c[0] = v_s1;
	assign flip_c[0] = flip_s1;
	assign side_c[0] = side_s1;
	assign vx_c[0] = dx_s1;
	assign vy_c[0] = dy_s1;
	assign rx_c[0] = UNIT_START;
	assign ry_c[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_dir
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_c[i+1] <= 1'b0;
			else if (en) v_c[i+1] <= v_c[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				flip_c[i+1] <= flip_c[i];
				side_c[i+1] <= side_c[i];
				if (vy_c[i] >= 0) begin
					vx_c[i+1] <= vx_c[i] + (vy_c[i] >>> i);
					vy_c[i+1] <= vy_c[i] - (vx_c[i] >>> i);
					rx_c[i+1] <= rx_c[i] - (ry_c[i] >>> i);
					ry_c[i+1] <= ry_c[i] + (rx_c[i] >>> i);
				end else begin
					vx_c[i+1] <= vx_c[i] - (vy_c[i] >>> i);
					vy_c[i+1] <= vy_c[i] + (vx_c[i] >>> i);
					rx_c[i+1] <= rx_c[i] + (ry_c[i] >>> i);
					ry_c[i+1] <= ry_c[i] - (rx_c[i] >>> i);
				end
			end
		end
	end

	// ---- stage 3: unit vector
	logic                     v_s3;
	side_a_t                  side_s3;
	logic signed [UNIT_W-1:0] ux_s3, uy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_c[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_c[N];
			if (side_c[N].degen) begin
				ux_s3 <= '0;
				uy_s3 <= '0;
			end else if (flip_c[N]) begin
				ux_s3 <= -rx_c[N];
				uy_s3 <= -ry_c[N];
			end else begin
				ux_s3 <= rx_c[N];
				uy_s3 <= ry_c[N];
			end
		end
	end

	// ---- stage 4: calibration products
	logic signed [POS_W-1:0]  feat [NUM_REGS];
	logic                     v_s4;
	side_a_t                  side_s4;
	logic signed [PROD_W-1:0] prod_s4 [4][NUM_REGS];

	assign feat[0] = side_s3.mid_x;
	assign feat[1] = side_s3.mid_y;
	assign feat[2] = POS_W'(ux_s3);
	assign feat[3] = POS_W'(uy_s3);
	assign feat[4] = FEAT_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			for (int k = 0; k < 4; k++) begin
				for (int r = 0; r < NUM_REGS; r++) begin
					prod_s4[k][r] <= feat[r] * $signed(regs_q[r][COEF_W*k +: COEF_W]);
				end
			end
		end
	end

	// ---- stage 5: calibration sums
	logic                    v_s5;
	side_a_t                 side_s5;
	logic signed [SUM_W-1:0] sum_s5 [4];
	logic signed [SUM_W-1:0] acc [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			acc[k] = '0;
			for (int r = 0; r < NUM_REGS; r++) acc[k] = acc[k] + SUM_W'(prod_s4[k][r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			for (int k = 0; k < 4; k++) sum_s5[k] <= acc[k];
		end
	end

	// ---- stage 6: pose rounding, yaw CORDIC setup
	logic signed [SUM_W-1:0] rnd [2];
	logic signed [POS_W-1:0] sat [2];
	logic                    v_s6;
	side_b_t                 side_s6;
	logic signed [VEC_W-1:0] ax_s6, ay_s6;
	logic [ANG_W-1:0]        z_s6;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rnd[k] = (sum_s5[k] + SUM_W'(2048)) >>> 12;
			if (rnd[k] > SUM_W'(POS_MAX)) sat[k] = POS_MAX;
			else if (rnd[k] < SUM_W'(POS_MIN)) sat[k] = POS_MIN;
			else sat[k] = POS_W'(rnd[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6.px <= sat[0];
			side_s6.py <= sat[1];
			side_s6.id <= side_s5.id;
			side_s6.tm <= side_s5.tm;
			side_s6.degen <= side_s5.degen;
			side_s6.yaw_zero <= side_s5.degen || (sum_s5[2] == 0 && sum_s5[3] == 0);
			if (sum_s5[2] < 0) begin
				ax_s6 <= -VEC_W'(sum_s5[2]);
				ay_s6 <= -VEC_W'(sum_s5[3]);
				z_s6 <= 32'h80000000;
			end else begin
				ax_s6 <= VEC_W'(sum_s5[2]);
				ay_s6 <= VEC_W'(sum_s5[3]);
				z_s6 <= '0;
			end
		end
	end

	// ---- yaw CORDIC
	logic                    v_y [N+1];
	side_b_t                 side_y [N+1];
	logic signed [VEC_W-1:0] yx_y [N+1];
	logic signed [VEC_W-1:0] yy_y [N+1];
	logic [ANG_W-1:0]        z_y [N+1];

	assign v_y[0] = v_s6;
	assign side_y[0] = side_s6;
	assign yx_y[0] = ax_s6;
	assign yy_y[0] = ay_s6;
	assign z_y[0] = z_s6;

	for (genvar i = 0; i < N; i++) begin : g_yaw
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_y[i+1] <= 1'b0;
			else if (en) v_y[i+1] <= v_y[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_y[i+1] <= side_y[i];
				if (yy_y[i] >= 0) begin
					yx_y[i+1] <= yx_y[i] + (yy_y[i] >>> i);
					yy_y[i+1] <= yy_y[i] - (yx_y[i] >>> i);
					z_y[i+1] <= z_y[i] + ATAN_BAM[i];
				end else begin
					yx_y[i+1] <= yx_y[i] - (yy_y[i] >>> i);
					yy_y[i+1] <= yy_y[i] + (yx_y[i] >>> i);
					z_y[i+1] <= z_y[i] - ATAN_BAM[i];
				end
			end
		end
	end

	// ---- stage 7: angle to radians
	logic               v_s7;
	side_b_t            side_s7;
	logic signed [63:0] ang_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_y[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_y[N];
			ang_s7 <= 64'($signed(z_y[N])) * 64'(PI_Q29);
		end
	end

	// ---- output register
	logic signed [63:0]      yaw_full;
	logic signed [YAW_W-1:0] yaw_c;

	always_comb begin
		yaw_full = (ang_s7 + (64'sd1 <<< 46)) >>> 47;
		if (side_s7.yaw_zero) yaw_c = '0;
		else if (yaw_full > 64'(YAW_LIMIT)) yaw_c = YAW_LIMIT;
		else if (yaw_full < -64'(YAW_LIMIT)) yaw_c = -YAW_LIMIT;
		else yaw_c = YAW_W'(yaw_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pose.valid <= 1'b0;
		else if (en) pose.valid <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pose.pose_x <= side_s7.px;
			pose.pose_y <= side_s7.py;
			pose.yaw <= yaw_c;
			pose.out_car_id <= side_s7.id;
			pose.out_time <= side_s7.tm;
			pose.degenerate <= side_s7.degen;
		end
	end

	`VPFM_ASSERT(a_degen_yaw, pose.valid && pose.degenerate |-> pose.yaw == 0, "degen yaw")
	`VPFM_ASSERT(a_yaw_range, pose.valid |-> pose.yaw <= YAW_LIMIT && pose.yaw >= -YAW_LIMIT, "yaw")
	`VPFM_ASSERT_ALWAYS(a_ready, pts.ready == (!pose.valid || pose.ready), "input ready")
	`VPFM_ASSERT(a_hold, pose.valid && !pose.ready |=> $stable(v_s7) && $stable(side_s7), "hold")
endmodule
